/* rtl/swms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types, constants and control codes of the sliding window message
// statistics block.
// ----------------------------------------------------------------------------
package swms_pkg;

  // default sizes
  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned DIST_LIMIT_DEF = 64;

  // field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned US_W    = 20;
  localparam int unsigned WIN_W   = 22;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned DIST_W  = 7;
  localparam int unsigned DEV_W   = 24;
  localparam int unsigned STAT_W  = 32;
  localparam int unsigned MSQ_W   = 10;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 216;

  // arithmetic constants
  localparam int unsigned MICROS_MAX = 999999;
  localparam int unsigned US_PER_S   = 1000000;
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned WINDOW_RST = 60000;
  localparam int unsigned RATE_SCALE = 256000;
  // floor(x / 1000) = (x * RECIP_M) >> RECIP_K for x below 2^20
  localparam int unsigned RECIP_K    = 30;
  localparam int unsigned RECIP_M    = 1073742;
  localparam int unsigned RECIP_W    = 21;

  // shared divider
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DVS_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // command codes on the input stream
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_EV_RD,
    ST_EV_DL,
    ST_EV_W,
    ST_AC_RD,
    ST_AC_CALC,
    ST_AC_W,
    ST_DI_RDI,
    ST_DI_LATI,
    ST_DI_RDJ,
    ST_DI_CMP,
    ST_MEAN_S,
    ST_MEAN_W,
    ST_SQ_RD,
    ST_SQ_D,
    ST_SQ_M,
    ST_SQ_A,
    ST_DEV_S,
    ST_DEV_W,
    ST_SQRT_S,
    ST_SQRT_W,
    ST_RATE_S,
    ST_RATE_W,
    ST_GAP_S,
    ST_GAP_W,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_I,
    RD_J
  } rd_sel_e;

  typedef enum logic {
    DL_EVICT,
    DL_GAP
  } dl_sel_e;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_DEV,
    DIV_RATE,
    DIV_GAP
  } div_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     clear;
    logic     append;
    rd_sel_e  rd_sel;
    logic     dl_start;
    dl_sel_e  dl_sel;
    logic     evict;
    logic     save_span;
    logic     i_clr;
    logic     i_inc;
    logic     j_clr;
    logic     j_inc;
    logic     acc_len;
    logic     acc_gap;
    logic     id_lat;
    logic     dist_inc;
    logic     sq_d;
    logic     sq_m;
    logic     sq_a;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     sqrt_store;
    logic     res_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clr;
    logic delta_vld;
    logic evict_req;
    logic i_zero;
    logic i_last;
    logic j_last;
    logic id_match;
    logic dist_full;
    logic div_done;
    logic sqrt_busy;
    logic win_zero;
    logic n_gt1;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/swms_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swms_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swms_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [swms_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [swms_pkg::DVS_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [swms_pkg::DIV_W-1:0]       quot_o
);
  import swms_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // one trial subtraction per cycle
  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

/* rtl/swms_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swms_dp
// Datapath: entry ring memories, time delta pipe, accumulators, divider,
// square root and the output register.
// ----------------------------------------------------------------------------
module swms_dp #(
  parameter int unsigned WINDOW_DEPTH   = swms_pkg::DEPTH_DEF,
  parameter int unsigned DISTINCT_LIMIT = swms_pkg::DIST_LIMIT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_cmd_i,
  input  wire logic [swms_pkg::ID_W-1:0]         in_id_i,
  input  wire logic [swms_pkg::LEN_W-1:0]        in_len_i,
  input  wire logic [swms_pkg::SEC_W-1:0]        in_sec_i,
  input  wire logic [swms_pkg::US_W-1:0]         in_us_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [swms_pkg::WIN_W-1:0]        cfg_data_i,
  input  wire swms_pkg::dp_cmd_t                 cmd_i,
  output swms_pkg::dp_sts_t                      sts_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [swms_pkg::OUT_TDATA_W-1:0]       out_tdata_o,
  output logic                                   out_tuser_o
);
  import swms_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned DC_W  = $clog2(DISTINCT_LIMIT + 1);
  localparam int unsigned SUM_W = LEN_W + CNT_W;
  localparam int unsigned GS_W  = STAT_W + CNT_W;
  localparam int unsigned SQ_W  = 2 * LEN_W + CNT_W;
  localparam int unsigned PRD_W = US_W + RECIP_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(WINDOW_DEPTH);
  localparam logic [DC_W-1:0]  LIMIT_C = DC_W'(DISTINCT_LIMIT);

  // ring memories
  logic [ID_W-1:0]  mem_id  [WINDOW_DEPTH];
  logic [LEN_W-1:0] mem_len [WINDOW_DEPTH];
  logic [SEC_W-1:0] mem_sec [WINDOW_DEPTH];
  logic [US_W-1:0]  mem_us  [WINDOW_DEPTH];
  logic [ID_W-1:0]  rd_id_q;
  logic [LEN_W-1:0] rd_len_q;
  logic [SEC_W-1:0] rd_sec_q;
  logic [US_W-1:0]  rd_us_q;

  // control registers
  logic [IDX_W-1:0] head_q;
  logic [CNT_W-1:0] fill_q;
  logic [IDX_W-1:0] i_q, j_q;
  logic [WIN_W-1:0] win_q;
  logic             clr_q;
  logic             ovf_q;
  logic [2:0]       dlv_q;
  logic [DC_W-1:0]  dist_q;
  logic             out_valid_q;
  logic [DIV_W-1:0] bit_q;

  // payload registers
  logic [ID_W-1:0]   now_id_q;
  logic [LEN_W-1:0]  now_len_q;
  logic [SEC_W-1:0]  now_sec_q;
  logic [US_W-1:0]   now_us_q;
  logic [SEC_W-1:0]  prev_sec_q;
  logic [US_W-1:0]   prev_us_q;
  logic [ID_W-1:0]   idi_q;
  logic [SEC_W-1:0]  ds1_q;
  logic [US_W-1:0]   du1_q;
  logic [STAT_W-1:0] ms2_q;
  logic [MSQ_W-1:0]  uq2_q;
  logic [STAT_W-1:0] dl_q;
  logic [SUM_W-1:0]  sum_q;
  logic [GS_W-1:0]   gsum_q;
  logic [STAT_W-1:0] gmin_q, gmax_q, gmean_q, span_q, rate_q;
  logic [LEN_W-1:0]  mean_q, d_q;
  logic [2*LEN_W-1:0] p_q;
  logic [SQ_W-1:0]   sq_q;
  logic [DEV_W-1:0]  dev_q;
  logic [DIV_W-1:0]  x_q, r_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;
  logic              out_tuser_q;

  // comb
  logic             full;
  logic [IDX_W-1:0] head_app, head_inc, wa, ra, rk;
  logic [CNT_W-1:0] fill_app;
  logic [IDX_W:0]   wsum, rsum;
  logic [SEC_W-1:0] sa, sb, ds;
  logic [US_W-1:0]  ua, ub, du;
  logic [US_W:0]    du_wide;
  logic [PRD_W-1:0] uprod;
  logic [DIV_W-1:0] div_a;
  logic [DVS_W-1:0] div_b;
  logic             div_done;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] sq_try;
  logic [US_W-1:0]  us_sat;
  logic             n_gt1;

  // ring addressing
  always_comb begin
    full     = fill_q == DEPTH_C;
    head_inc = (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
    head_app = full ? head_inc : head_q;
    fill_app = full ? DEPTH_C - 1'b1 : fill_q;
    wsum     = {1'b0, head_app} + (IDX_W + 1)'(fill_app);
    if (wsum >= DEPTH_X) begin
      wsum = wsum - DEPTH_X;
    end
    wa = wsum[IDX_W-1:0];
    case (cmd_i.rd_sel)
      RD_HEAD: rk = '0;
      RD_I:    rk = i_q;
      RD_J:    rk = j_q;
      default: rk = '0;
    endcase
    rsum = {1'b0, head_q} + {1'b0, rk};
    if (rsum >= DEPTH_X) begin
      rsum = rsum - DEPTH_X;
    end
    ra = rsum[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_id[wa]  <= now_id_q;
      mem_len[wa] <= now_len_q;
      mem_sec[wa] <= now_sec_q;
      mem_us[wa]  <= now_us_q;
    end
    rd_id_q  <= mem_id[ra];
    rd_len_q <= mem_len[ra];
    rd_sec_q <= mem_sec[ra];
    rd_us_q  <= mem_us[ra];
  end

  // time delta operands, first stage
  always_comb begin
    if (cmd_i.dl_sel == DL_EVICT) begin
      sa = now_sec_q;
      ua = now_us_q;
      sb = rd_sec_q;
      ub = rd_us_q;
    end else begin
      sa = rd_sec_q;
      ua = rd_us_q;
      sb = prev_sec_q;
      ub = prev_us_q;
    end
    if (ua >= ub) begin
      du_wide = (US_W + 1)'(ua) - (US_W + 1)'(ub);
      ds      = sa - sb;
    end else begin
      du_wide = (US_W + 1)'(ua) + (US_W + 1)'(US_PER_S) - (US_W + 1)'(ub);
      ds      = sa - sb - 1'b1;
    end
    du    = du_wide[US_W-1:0];
    uprod = PRD_W'(du1_q) * PRD_W'(RECIP_M);
  end

  assign us_sat = (in_us_i > US_W'(MICROS_MAX)) ? US_W'(MICROS_MAX) : in_us_i;
  assign n_gt1  = fill_q > CNT_W'(1);

  // divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_a = DIV_W'(sum_q);
        div_b = DVS_W'(fill_q);
      end
      DIV_DEV: begin
        div_a = DIV_W'({sq_q, 16'h0000});
        div_b = DVS_W'(fill_q);
      end
      DIV_RATE: begin
        div_a = DIV_W'(STAT_W'(fill_q) * STAT_W'(RATE_SCALE));
        div_b = DVS_W'(win_q);
      end
      DIV_GAP: begin
        div_a = DIV_W'(gsum_q);
        div_b = DVS_W'(fill_q - 1'b1);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  swms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quo)
  );

  assign sq_try = r_q + bit_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      win_q       <= WIN_W'(WINDOW_RST);
      clr_q       <= 1'b0;
      ovf_q       <= 1'b0;
      dlv_q       <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        clr_q <= in_cmd_i == CMD_CLEAR;
      end
      if (cmd_i.clear) begin
        head_q <= '0;
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end
      if (cmd_i.append) begin
        head_q <= head_app;
        fill_q <= fill_app + 1'b1;
        ovf_q  <= full;
        dist_q <= '0;
      end
      if (cmd_i.evict) begin
        head_q <= head_inc;
        fill_q <= fill_q - 1'b1;
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.dist_inc && dist_q != LIMIT_C) begin
        dist_q <= dist_q + 1'b1;
      end
      dlv_q <= {dlv_q[1:0], cmd_i.dl_start};
      if (cmd_i.sqrt_start) begin
        bit_q <= DIV_W'(1) << (DIV_W - 2);
      end else begin
        bit_q <= bit_q >> 2;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_id_q  <= in_id_i;
      now_len_q <= in_len_i;
      now_sec_q <= in_sec_i;
      now_us_q  <= us_sat;
    end
    // delta pipe: borrow, scale, add
    ds1_q <= ds;
    du1_q <= du;
    ms2_q <= ds1_q * STAT_W'(MS_PER_S);
    uq2_q <= uprod[RECIP_K +: MSQ_W];
    dl_q  <= ms2_q + STAT_W'(uq2_q);
    if (cmd_i.append) begin
      sum_q   <= '0;
      gsum_q  <= '0;
      gmin_q  <= '1;
      gmax_q  <= '0;
      sq_q    <= '0;
      rate_q  <= '0;
      gmean_q <= '0;
    end
    if (cmd_i.save_span) begin
      span_q <= dl_q;
    end
    if (cmd_i.acc_len) begin
      sum_q      <= sum_q + SUM_W'(rd_len_q);
      prev_sec_q <= rd_sec_q;
      prev_us_q  <= rd_us_q;
    end
    if (cmd_i.acc_gap) begin
      gsum_q <= gsum_q + GS_W'(dl_q);
      if (dl_q < gmin_q) begin
        gmin_q <= dl_q;
      end
      if (dl_q > gmax_q) begin
        gmax_q <= dl_q;
      end
    end
    if (cmd_i.id_lat) begin
      idi_q <= rd_id_q;
    end
    // squared deviation about the mean
    if (cmd_i.sq_d) begin
      d_q <= (rd_len_q >= mean_q) ? rd_len_q - mean_q : mean_q - rd_len_q;
    end
    if (cmd_i.sq_m) begin
      p_q <= d_q * d_q;
    end
    if (cmd_i.sq_a) begin
      sq_q <= sq_q + SQ_W'(p_q);
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DIV_MEAN: mean_q <= quo[LEN_W-1:0];
        DIV_RATE: rate_q <= (quo > DIV_W'({STAT_W{1'b1}})) ? '1 : quo[STAT_W-1:0];
        DIV_GAP:  gmean_q <= quo[STAT_W-1:0];
        default:  ;
      endcase
    end
    // bit pair square root
    if (cmd_i.sqrt_start) begin
      x_q <= quo;
      r_q <= '0;
    end else if (bit_q != '0) begin
      if (x_q >= sq_try) begin
        x_q <= x_q - sq_try;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
    if (cmd_i.sqrt_store) begin
      dev_q <= (r_q > DIV_W'({DEV_W{1'b1}})) ? '1 : r_q[DEV_W-1:0];
    end
    // output register
    if (cmd_i.res_load) begin
      if (clr_q) begin
        out_tdata_q <= '0;
        out_tuser_q <= 1'b0;
      end else begin
        out_tdata_q <= {n_gt1 ? gmax_q : '0,
                        n_gt1 ? gmin_q : '0,
                        gmean_q,
                        n_gt1 ? span_q : '0,
                        rate_q,
                        dev_q,
                        mean_q,
                        DIST_W'(dist_q),
                        COUNT_W'(fill_q)};
        out_tuser_q <= ovf_q;
      end
    end
  end

  // status
  always_comb begin
    sts_o.is_clr    = clr_q;
    sts_o.delta_vld = dlv_q[2];
    sts_o.evict_req = dl_q > STAT_W'(win_q);
    sts_o.i_zero    = i_q == '0;
    sts_o.i_last    = (CNT_W'(i_q) + 1'b1) == fill_q;
    sts_o.j_last    = ({1'b0, j_q} + 1'b1) == {1'b0, i_q};
    sts_o.id_match  = rd_id_q == idi_q;
    sts_o.dist_full = dist_q == LIMIT_C;
    sts_o.div_done  = div_done;
    sts_o.sqrt_busy = bit_q != '0;
    sts_o.win_zero  = win_q == '0;
    sts_o.n_gt1     = n_gt1;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = out_tdata_q;
  assign out_tuser_o = out_tuser_q;

endmodule
`default_nettype wire

/* rtl/swms_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swms_ctrl
// Sequencer: append, eviction, statistics passes over the window and the
// final divisions.
// ----------------------------------------------------------------------------
module swms_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire swms_pkg::dp_sts_t sts_i,
  output swms_pkg::dp_cmd_t      cmd_o
);
  import swms_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_START;
      ST_START:   state_d = sts_i.is_clr ? ST_DONE : ST_EV_RD;
      ST_EV_RD:   state_d = ST_EV_DL;
      ST_EV_DL:   state_d = ST_EV_W;
      ST_EV_W: begin
        if (sts_i.delta_vld) state_d = sts_i.evict_req ? ST_EV_RD : ST_AC_RD;
      end
      ST_AC_RD:   state_d = ST_AC_CALC;
      ST_AC_CALC: begin
        if (!sts_i.i_zero) state_d = ST_AC_W;
        else state_d = sts_i.i_last ? ST_DI_RDI : ST_AC_RD;
      end
      ST_AC_W: begin
        if (sts_i.delta_vld) state_d = sts_i.i_last ? ST_DI_RDI : ST_AC_RD;
      end
      ST_DI_RDI:  state_d = sts_i.dist_full ? ST_MEAN_S : ST_DI_LATI;
      ST_DI_LATI: begin
        if (!sts_i.i_zero) state_d = ST_DI_RDJ;
        else state_d = sts_i.i_last ? ST_MEAN_S : ST_DI_RDI;
      end
      ST_DI_RDJ:  state_d = ST_DI_CMP;
      ST_DI_CMP: begin
        if (sts_i.id_match || sts_i.j_last) begin
          state_d = sts_i.i_last ? ST_MEAN_S : ST_DI_RDI;
        end else begin
          state_d = ST_DI_RDJ;
        end
      end
      ST_MEAN_S:  state_d = ST_MEAN_W;
      ST_MEAN_W:  if (sts_i.div_done) state_d = ST_SQ_RD;
      ST_SQ_RD:   state_d = ST_SQ_D;
      ST_SQ_D:    state_d = ST_SQ_M;
      ST_SQ_M:    state_d = ST_SQ_A;
      ST_SQ_A:    state_d = sts_i.i_last ? ST_DEV_S : ST_SQ_RD;
      ST_DEV_S:   state_d = ST_DEV_W;
      ST_DEV_W:   if (sts_i.div_done) state_d = ST_SQRT_S;
      ST_SQRT_S:  state_d = ST_SQRT_W;
      ST_SQRT_W:  if (!sts_i.sqrt_busy) state_d = ST_RATE_S;
      ST_RATE_S:  state_d = sts_i.win_zero ? ST_GAP_S : ST_RATE_W;
      ST_RATE_W:  if (sts_i.div_done) state_d = ST_GAP_S;
      ST_GAP_S:   state_d = sts_i.n_gt1 ? ST_GAP_W : ST_DONE;
      ST_GAP_W:   if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE:    if (sts_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START: begin
        cmd_o.clear  = sts_i.is_clr;
        cmd_o.append = !sts_i.is_clr;
      end
      ST_EV_RD: cmd_o.rd_sel = RD_HEAD;
      ST_EV_DL: begin
        cmd_o.dl_start = 1'b1;
        cmd_o.dl_sel   = DL_EVICT;
      end
      ST_EV_W: begin
        if (sts_i.delta_vld) begin
          cmd_o.evict     = sts_i.evict_req;
          cmd_o.save_span = !sts_i.evict_req;
          cmd_o.i_clr     = !sts_i.evict_req;
        end
      end
      ST_AC_RD: cmd_o.rd_sel = RD_I;
      ST_AC_CALC: begin
        cmd_o.acc_len = 1'b1;
        if (!sts_i.i_zero) begin
          cmd_o.dl_start = 1'b1;
          cmd_o.dl_sel   = DL_GAP;
        end else begin
          cmd_o.i_clr = sts_i.i_last;
          cmd_o.i_inc = !sts_i.i_last;
        end
      end
      ST_AC_W: begin
        if (sts_i.delta_vld) begin
          cmd_o.acc_gap = 1'b1;
          cmd_o.i_clr   = sts_i.i_last;
          cmd_o.i_inc   = !sts_i.i_last;
        end
      end
      ST_DI_RDI: cmd_o.rd_sel = RD_I;
      ST_DI_LATI: begin
        cmd_o.id_lat = 1'b1;
        cmd_o.j_clr  = 1'b1;
        if (sts_i.i_zero) begin
          cmd_o.dist_inc = 1'b1;
          cmd_o.i_inc    = 1'b1;
        end
      end
      ST_DI_RDJ: cmd_o.rd_sel = RD_J;
      ST_DI_CMP: begin
        if (sts_i.id_match) begin
          cmd_o.i_inc = 1'b1;
        end else if (sts_i.j_last) begin
          cmd_o.dist_inc = 1'b1;
          cmd_o.i_inc    = 1'b1;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      ST_MEAN_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
        cmd_o.i_clr     = 1'b1;
      end
      ST_MEAN_W: begin
        cmd_o.div_sel   = DIV_MEAN;
        cmd_o.div_store = sts_i.div_done;
      end
      ST_SQ_RD: cmd_o.rd_sel = RD_I;
      ST_SQ_D:  cmd_o.sq_d = 1'b1;
      ST_SQ_M:  cmd_o.sq_m = 1'b1;
      ST_SQ_A: begin
        cmd_o.sq_a  = 1'b1;
        cmd_o.i_inc = 1'b1;
      end
      ST_DEV_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DEV;
      end
      ST_DEV_W: begin
        cmd_o.div_sel   = DIV_DEV;
        cmd_o.div_store = sts_i.div_done;
      end
      ST_SQRT_S: cmd_o.sqrt_start = 1'b1;
      ST_SQRT_W: cmd_o.sqrt_store = !sts_i.sqrt_busy;
      ST_RATE_S: begin
        cmd_o.div_start = !sts_i.win_zero;
        cmd_o.div_sel   = DIV_RATE;
      end
      ST_RATE_W: begin
        cmd_o.div_sel   = DIV_RATE;
        cmd_o.div_store = sts_i.div_done;
      end
      ST_GAP_S: begin
        cmd_o.div_start = sts_i.n_gt1;
        cmd_o.div_sel   = DIV_GAP;
      end
      ST_GAP_W: begin
        cmd_o.div_sel   = DIV_GAP;
        cmd_o.div_store = sts_i.div_done;
      end
      ST_DONE: cmd_o.res_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sliding_window_message_stats.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_message_stats
// Time based sliding window statistics over a stream of message arrivals.
// ----------------------------------------------------------------------------
// Each input item is either an arrival or a clear command and produces one
// result item. An item is processed alone, from acceptance to the loaded
// result. Its time grows with the eviction checks, the entries left in the
// window and the id comparisons of the distinct id scan (up to n*(n-1)/2
// comparisons, stopping early once the distinct limit is reached). The id
// scan over the single read port of the entry memory dominates for full
// windows; up to four divisions and a square root make up the rest. A clear
// command skips the eviction check and the statistics passes. The next item
// is accepted while the previous result waits in the output register.
module sliding_window_message_stats #(
  parameter int unsigned WINDOW_DEPTH   = swms_pkg::DEPTH_DEF,
  parameter int unsigned DISTINCT_LIMIT = swms_pkg::DIST_LIMIT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // config write, window length in ms
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [swms_pkg::WIN_W-1:0]          cfg_data_i,
  // input items
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // message_id, message_length, time_seconds, time_micros, zero pad
  input  wire logic [swms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command
  input  wire logic                                s_axis_tuser,
  // result items
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // count_in_window, distinct_ids, mean_length, length_deviation,
  // rate_per_second, flow_span_ms, mean_gap_ms, min_gap_ms, max_gap_ms
  output logic [swms_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // window_overflow
  output logic                                     m_axis_tuser
);
  import swms_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  swms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swms_dp #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .DISTINCT_LIMIT (DISTINCT_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (s_axis_tuser),
    .in_id_i     (s_axis_tdata[15:0]),
    .in_len_i    (s_axis_tdata[31:16]),
    .in_sec_i    (s_axis_tdata[63:32]),
    .in_us_i     (s_axis_tdata[83:64]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

endmodule
`default_nettype wire
